// ----- design/npta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npta_pkg
// Shared types, codes and sizes of the neighbor port table with aging.
// ----------------------------------------------------------------------------
package npta_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int LIM_W       = $clog2(ENTRY_COUNT + 1);
  localparam int PORT_W      = 6;
  localparam int CMD_W       = 3;
  localparam int ID_W        = 16;
  localparam int AGE_W       = 16;
  localparam int DLY_W       = 32;
  localparam int TYPE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int ACT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;

  localparam logic [ACT_W-1:0]  ACTIVE_PORTS_RST = ACT_W'(16);
  localparam logic [AGE_W-1:0]  MAX_AGE_RST      = AGE_W'(4);
  localparam logic [TYPE_W-1:0] PONG_TYPE        = TYPE_W'(2);
  localparam logic [AGE_W-1:0]  AGE_MAX          = '1;
  localparam logic [IDX_W-1:0]  LAST_IDX         = IDX_W'(ENTRY_COUNT - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_SWEEP       = 3'd1,
    CMD_REFRESH     = 3'd2,
    CMD_PONG        = 3'd3,
    CMD_LOOKUP_PORT = 3'd4,
    CMD_LOOKUP_ID   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_INVALID  = 2'd1,
    STS_RANGE    = 2'd2,
    STS_NOT_PONG = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_PORTS = 2'd0,
    CFG_MAX_AGE      = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [ID_W-1:0]  nbr;
    logic [DLY_W-1:0] dly;
  } entry_t;

endpackage

// ----- design/npta_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npta_cell
// One table entry of the rotating ring; takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module npta_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  npta_pkg::entry_t d,
  output npta_pkg::entry_t q
);
  import npta_pkg::*;

  logic             valid_r;
  logic [AGE_W-1:0] age_r;
  logic [ID_W-1:0]  nbr_r;
  logic [DLY_W-1:0] dly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else if (shift) begin
      valid_r <= d.valid;
      age_r   <= d.age;
    end
  end

  // Neighbor id and delay are only read while the entry is valid.
  always_ff @(posedge clk) begin
    if (shift) begin
      nbr_r <= d.nbr;
      dly_r <= d.dly;
    end
  end

  assign q = '{valid: valid_r, age: age_r, nbr: nbr_r, dly: dly_r};

endmodule

// ----- design/npta_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npta_ctrl
// Command sequencer: walks the ring once per request, updates the entry at
// the head and builds the result stream.
// ----------------------------------------------------------------------------
module npta_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [npta_pkg::CMD_W-1:0]   in_cmd,
  input  logic [npta_pkg::PORT_W-1:0]  in_port,
  input  logic [npta_pkg::ID_W-1:0]    in_search_id,
  input  logic [npta_pkg::TYPE_W-1:0]  in_packet_type,
  input  logic [npta_pkg::ID_W-1:0]    in_from_id,
  input  logic [npta_pkg::DLY_W-1:0]   in_sent_time,
  input  logic [npta_pkg::DLY_W-1:0]   in_now,
  input  logic [npta_pkg::ACT_W-1:0]   active_ports,
  input  logic [npta_pkg::AGE_W-1:0]   max_age,
  input  npta_pkg::entry_t             head,
  output npta_pkg::entry_t             tail,
  output logic                         shift,
  output logic                         out_strobe,
  output logic [npta_pkg::STATUS_W-1:0] out_status,
  output logic                         out_changed,
  output logic [npta_pkg::ID_W-1:0]    out_neighbor_id,
  output logic [npta_pkg::PORT_W-1:0]  out_found_port,
  output logic [npta_pkg::DLY_W-1:0]   out_link_delay,
  output logic                         out_last
);
  import npta_pkg::*;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic              port_ok_r, port_ok_nxt;
  logic [ID_W-1:0]   sid_r, sid_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;

  status_t           fin_status_r, fin_status_nxt;
  logic              fin_changed_r, fin_changed_nxt;
  logic [ID_W-1:0]   fin_nid_r, fin_nid_nxt;
  logic [PORT_W-1:0] fin_fport_r, fin_fport_nxt;
  logic [DLY_W-1:0]  fin_dly_r, fin_dly_nxt;

  logic              pend_r, pend_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_changed_r, out_changed_nxt;
  logic [ID_W-1:0]   out_nid_r, out_nid_nxt;
  logic [PORT_W-1:0] out_fport_r, out_fport_nxt;
  logic [DLY_W-1:0]  out_dly_r, out_dly_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LIM_W-1:0]  lim_now;
  logic              accept;
  logic              in_rng;
  logic              match;

  always_comb begin
    if (active_ports >= ACT_W'(ENTRY_COUNT)) lim_now = LIM_W'(ENTRY_COUNT);
    else                                     lim_now = active_ports[LIM_W-1:0];
  end

  assign busy   = (state_r == ST_RUN);
  assign accept = start && !busy && (in_cmd <= CMD_W'(CMD_LOOKUP_ID));
  assign shift  = (state_r == ST_RUN);
  assign in_rng = (ACT_W'(idx_r) < ACT_W'(lim_r));
  assign match  = port_ok_r && (port_r == PORT_W'(idx_r));

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cmd_nxt         = cmd_r;
    port_nxt        = port_r;
    port_ok_nxt     = port_ok_r;
    sid_nxt         = sid_r;
    lim_nxt         = lim_r;
    fin_status_nxt  = fin_status_r;
    fin_changed_nxt = fin_changed_r;
    fin_nid_nxt     = fin_nid_r;
    fin_fport_nxt   = fin_fport_r;
    fin_dly_nxt     = fin_dly_r;
    pend_nxt        = pend_r;
    pend_id_nxt     = pend_id_r;
    out_strobe_nxt  = 1'b0;
    out_status_nxt  = out_status_r;
    out_changed_nxt = out_changed_r;
    out_nid_nxt     = out_nid_r;
    out_fport_nxt   = out_fport_r;
    out_dly_nxt     = out_dly_r;
    out_last_nxt    = out_last_r;
    tail            = head;

    case (state_r)
      ST_RUN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) state_nxt = ST_DONE;
        case (cmd_r)
          CMD_TICK: begin
            if (in_rng && head.valid && head.age != AGE_MAX) begin
              tail.age = head.age + AGE_W'(1);
            end
          end
          CMD_SWEEP: begin
            if (in_rng && head.valid && head.age > max_age) begin
              tail.valid = 1'b0;
              // The previous expiry is now known not to be the final one.
              if (pend_r) begin
                out_strobe_nxt  = 1'b1;
                out_status_nxt  = STS_OK;
                out_changed_nxt = 1'b1;
                out_nid_nxt     = pend_id_r;
                out_fport_nxt   = '0;
                out_dly_nxt     = '0;
                out_last_nxt    = 1'b0;
              end
              pend_nxt    = 1'b1;
              pend_id_nxt = head.nbr;
            end
          end
          CMD_REFRESH: begin
            if (match && head.valid) begin
              tail.age       = '0;
              fin_status_nxt = STS_OK;
            end
          end
          CMD_PONG: begin
            if (match && fin_status_r == STS_OK) begin
              fin_changed_nxt = !head.valid || head.dly != fin_dly_r ||
                                head.nbr != fin_nid_r;
              tail.valid = 1'b1;
              tail.age   = '0;
              tail.nbr   = fin_nid_r;
              tail.dly   = fin_dly_r;
            end
          end
          CMD_LOOKUP_PORT: begin
            if (match && head.valid) begin
              fin_status_nxt = STS_OK;
              fin_nid_nxt    = head.nbr;
              fin_dly_nxt    = head.dly;
            end
          end
          CMD_LOOKUP_ID: begin
            if (in_rng && head.valid && head.nbr == sid_r &&
                fin_status_r == STS_INVALID) begin
              fin_status_nxt = STS_OK;
              fin_fport_nxt  = PORT_W'(idx_r);
            end
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        state_nxt       = ST_IDLE;
        out_strobe_nxt  = 1'b1;
        out_last_nxt    = 1'b1;
        out_status_nxt  = fin_status_r;
        out_changed_nxt = fin_changed_r;
        out_nid_nxt     = fin_nid_r;
        out_fport_nxt   = fin_fport_r;
        out_dly_nxt     = fin_dly_r;
        if (cmd_r == CMD_SWEEP && pend_r) begin
          out_changed_nxt = 1'b1;
          out_nid_nxt     = pend_id_r;
        end
      end
      default: begin
      end
    endcase

    if (accept) begin
      state_nxt       = ST_RUN;
      idx_nxt         = '0;
      cmd_nxt         = cmd_t'(in_cmd);
      port_nxt        = in_port;
      port_ok_nxt     = (ACT_W'(in_port) < ACT_W'(lim_now));
      sid_nxt         = in_search_id;
      lim_nxt         = lim_now;
      pend_nxt        = 1'b0;
      fin_status_nxt  = STS_OK;
      fin_changed_nxt = 1'b0;
      fin_nid_nxt     = '0;
      fin_fport_nxt   = '0;
      fin_dly_nxt     = '0;
      case (cmd_t'(in_cmd))
        CMD_REFRESH, CMD_LOOKUP_PORT: begin
          fin_status_nxt = port_ok_nxt ? STS_INVALID : STS_RANGE;
        end
        CMD_PONG: begin
          if (in_packet_type != PONG_TYPE) begin
            fin_status_nxt = STS_NOT_PONG;
          end else if (!port_ok_nxt) begin
            fin_status_nxt = STS_RANGE;
          end else begin
            fin_nid_nxt = in_from_id;
            fin_dly_nxt = in_now - in_sent_time;
          end
        end
        CMD_LOOKUP_ID: begin
          fin_status_nxt = STS_INVALID;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    port_r        <= port_nxt;
    port_ok_r     <= port_ok_nxt;
    sid_r         <= sid_nxt;
    lim_r         <= lim_nxt;
    fin_status_r  <= fin_status_nxt;
    fin_changed_r <= fin_changed_nxt;
    fin_nid_r     <= fin_nid_nxt;
    fin_fport_r   <= fin_fport_nxt;
    fin_dly_r     <= fin_dly_nxt;
    pend_id_r     <= pend_id_nxt;
    out_status_r  <= out_status_nxt;
    out_changed_r <= out_changed_nxt;
    out_nid_r     <= out_nid_nxt;
    out_fport_r   <= out_fport_nxt;
    out_dly_r     <= out_dly_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_changed     = out_changed_r;
  assign out_neighbor_id = out_nid_r;
  assign out_found_port  = out_fport_r;
  assign out_link_delay  = out_dly_r;
  assign out_last        = out_last_r;

  // A walk always covers the whole ring before finishing.
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && idx_r != LAST_IDX |=> state_r == ST_RUN)
    else $error("ring walk ended early");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && idx_r == LAST_IDX |=> state_r == ST_DONE)
    else $error("ring walk did not finish");

  // Every request closes with exactly one final result.
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> out_strobe_r && out_last_r)
    else $error("final result missing");

  // Only a sweep produces results that are not final.
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_last_r |-> cmd_r == CMD_SWEEP && out_changed_r)
    else $error("unexpected intermediate result");

endmodule

// ----- design/neighbor_port_table_aging_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_port_table_aging_unit
// Per-port neighbor table with aging, held in a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// Every request walks the ring of ENTRY_COUNT cells once, one entry per cycle.
// The final result comes after the walk; expired ids of a sweep come out
// during the walk, and the last of them with the final result. A new request
// is taken in the cycle before the final result. The receiver cannot stall.
// Synchronous active-low reset invalidates all entries, zeroing their ages,
// and loads register defaults.
module neighbor_port_table_aging_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [npta_pkg::CMD_W-1:0]    in_cmd,
  input  logic [npta_pkg::PORT_W-1:0]   in_port,
  input  logic [npta_pkg::ID_W-1:0]     in_search_id,
  input  logic [npta_pkg::TYPE_W-1:0]   in_packet_type,
  input  logic [npta_pkg::ID_W-1:0]     in_from_id,
  input  logic [npta_pkg::DLY_W-1:0]    in_sent_time,
  input  logic [npta_pkg::DLY_W-1:0]    in_now,
  output logic                          out_strobe,
  output logic [npta_pkg::STATUS_W-1:0] out_status,
  output logic                          out_changed,
  output logic [npta_pkg::ID_W-1:0]     out_neighbor_id,
  output logic [npta_pkg::PORT_W-1:0]   out_found_port,
  output logic [npta_pkg::DLY_W-1:0]    out_link_delay,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [npta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [npta_pkg::CFG_W-1:0]    cfg_wdata
);
  import npta_pkg::*;

  logic [ACT_W-1:0] active_ports_r;
  logic [AGE_W-1:0] max_age_r;
  entry_t           ent [ENTRY_COUNT];
  entry_t           tail;
  logic             shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ports_r <= ACTIVE_PORTS_RST;
      max_age_r      <= MAX_AGE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_PORTS: active_ports_r <= cfg_wdata[ACT_W-1:0];
        CFG_MAX_AGE:      max_age_r      <= cfg_wdata[AGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The ring moves toward cell 0; the updated head entry re-enters at the top.
  for (genvar k = 0; k < ENTRY_COUNT; k++) begin : g_cell
    entry_t d;
    if (k == ENTRY_COUNT - 1) begin : g_top
      assign d = tail;
    end else begin : g_mid
      assign d = ent[k+1];
    end
    npta_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     (d),
      .q     (ent[k])
    );
  end

  npta_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_port         (in_port),
    .in_search_id    (in_search_id),
    .in_packet_type  (in_packet_type),
    .in_from_id      (in_from_id),
    .in_sent_time    (in_sent_time),
    .in_now          (in_now),
    .active_ports    (active_ports_r),
    .max_age         (max_age_r),
    .head            (ent[0]),
    .tail            (tail),
    .shift           (shift),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_changed     (out_changed),
    .out_neighbor_id (out_neighbor_id),
    .out_found_port  (out_found_port),
    .out_link_delay  (out_link_delay),
    .out_last        (out_last)
  );

endmodule
